FILE: sv/sifl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sifl_pkg
// shared types and constants of the scoped in-flight limiter
// ----------------------------------------------------------------------------
package sifl_pkg;

    // number of per-stream gates, a power of two
    localparam int STREAMS   = 64;
    localparam int STREAM_AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    localparam int CNT_W   = 10;
    localparam int SCOPE_W = 2;
    localparam int POOL_W  = 2;
    localparam int SID_W   = 6;
    localparam int CFG_AW  = 1;

    // gate scope codes
    localparam logic [SCOPE_W-1:0] SCOPE_GLOBAL = 2'd0;
    localparam logic [SCOPE_W-1:0] SCOPE_STREAM = 2'd1;
    localparam logic [SCOPE_W-1:0] SCOPE_POOL   = 2'd2;

    // pool codes
    localparam logic [POOL_W-1:0] POOL_VECTOR = 2'd0;
    localparam logic [POOL_W-1:0] POOL_CUBE   = 2'd1;

    // request opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_GATE_SCOPE  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_DEPTH_LIMIT = 1'd1;

    localparam logic [CNT_W-1:0] DEPTH_LIMIT_RST = 10'd8;

    typedef enum logic [1:0] {
        GATE_GLOBAL,
        GATE_VECTOR,
        GATE_CUBE,
        GATE_STREAM
    } t_gate;

endpackage
`default_nettype wire

FILE: sv/sifl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sifl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module sifl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire                                   i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/scoped_in_flight_limiter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scoped_in_flight_limiter_unit
// counting credit gates limiting in-flight tasks, global, per stream or per pool
// ----------------------------------------------------------------------------
// usage:
//   request channel (i_in_valid / o_in_ready) carries opcode, stream id and
//   pool; result channel (o_out_valid / i_out_ready) returns granted, the
//   gate count after the step and an underflow flag, one result per request.
//   the stream table ram is read at acceptance, the request is resolved in the
//   execute register and the result is loaded into the output register.
//   throughput is one request per cycle while the receiver does not stall; the
//   single read-modify-write of the selected gate per cycle sets that figure,
//   with a bypass of the last stream table write covering back to back
//   requests on one stream.
//   when the receiver stalls, the result holds and one more request can
//   wait in the execute register; after that o_in_ready drops.
//   reset (synchronous, active low) clears all counts, sets scope to global
//   and the depth limit to 8; the stream table is marked empty by per-entry
//   valid bits, so no clearing pass is needed and requests are taken at once.
//   configuration writes (i_cfg_we) take effect in the next cycle; the user must
//   only make them while no transaction is in flight; the block never checks.
// ----------------------------------------------------------------------------
module scoped_in_flight_limiter_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration
    input  wire                        i_cfg_we,
    input  wire  [sifl_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire  [sifl_pkg::CNT_W-1:0]  i_cfg_wdata,
    // requests
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_opcode,
    input  wire  [sifl_pkg::SID_W-1:0]  i_stream_id,
    input  wire  [sifl_pkg::POOL_W-1:0] i_pool,
    // results
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic                       o_granted,
    output logic [sifl_pkg::CNT_W-1:0]  o_count_after,
    output logic                       o_underflow
);

    import sifl_pkg::*;

    // configuration registers
    logic [SCOPE_W-1:0]   r_scope;
    logic [CNT_W-1:0]     r_limit;

    // gate counters
    logic [CNT_W-1:0]     r_global_cnt;
    logic [CNT_W-1:0]     r_vector_cnt;
    logic [CNT_W-1:0]     r_cube_cnt;
    logic [STREAMS-1:0]   r_strm_vld;

    // execute register
    logic                 r_s1_vld;
    logic                 r_s1_op;
    logic [STREAM_AW-1:0] r_s1_sidx;
    logic [POOL_W-1:0]    r_s1_pool;

    // bypass of the last stream table write
    logic                 r_fwd_vld;
    logic [STREAM_AW-1:0] r_fwd_addr;
    logic [CNT_W-1:0]     r_fwd_cnt;

    // output register
    logic                 r_out_vld;
    logic                 r_out_granted;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_underflow;

    logic                 in_fire;
    logic                 s1_adv;
    logic                 s1_fire;
    logic [STREAM_AW-1:0] in_sidx;
    logic [CNT_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]     strm_cnt;
    t_gate                gate;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_granted;
    logic                 n_underflow;
    logic                 strm_we;

    // stream id modulo the table size
    assign in_sidx    = i_stream_id[STREAM_AW-1:0];
    assign s1_adv     = !r_out_vld || i_out_ready;
    assign s1_fire    = r_s1_vld && s1_adv;
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    sifl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (STREAMS)
    ) u_strm_ram (
        .i_clk   (i_clk),
        .i_we    (strm_we),
        .i_waddr (r_s1_sidx),
        .i_wdata (n_cnt),
        .i_re    (in_fire),
        .i_raddr (in_sidx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_sidx)) begin
            strm_cnt = r_fwd_cnt;
        end else if (r_strm_vld[r_s1_sidx]) begin
            strm_cnt = ram_rdata;
        end else begin
            strm_cnt = '0;
        end
    end

    always_comb begin
        case (r_scope)
            SCOPE_STREAM: gate = GATE_STREAM;
            SCOPE_POOL: begin
                if (r_s1_pool == POOL_VECTOR) begin
                    gate = GATE_VECTOR;
                end else if (r_s1_pool == POOL_CUBE) begin
                    gate = GATE_CUBE;
                end else begin
                    gate = GATE_GLOBAL;
                end
            end
            default: gate = GATE_GLOBAL;
        endcase
    end

    always_comb begin
        case (gate)
            GATE_VECTOR: cur_cnt = r_vector_cnt;
            GATE_CUBE:   cur_cnt = r_cube_cnt;
            GATE_STREAM: cur_cnt = strm_cnt;
            default:     cur_cnt = r_global_cnt;
        endcase
    end

    always_comb begin
        n_cnt       = cur_cnt;
        n_granted   = 1'b0;
        n_underflow = 1'b0;
        if (r_s1_op == OP_ACQUIRE) begin
            // count below limit means it is below 1023, no wrap
            if (cur_cnt < r_limit) begin
                n_cnt     = cur_cnt + 1'b1;
                n_granted = 1'b1;
            end
        end else begin
            if (cur_cnt == '0) begin
                n_underflow = 1'b1;
            end else begin
                n_cnt = cur_cnt - 1'b1;
            end
        end
    end

    assign strm_we = s1_fire && (gate == GATE_STREAM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scope <= SCOPE_GLOBAL;
            r_limit <= DEPTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GATE_SCOPE:  r_scope <= i_cfg_wdata[SCOPE_W-1:0];
                CFG_DEPTH_LIMIT: r_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_cnt <= '0;
            r_vector_cnt <= '0;
            r_cube_cnt   <= '0;
            r_strm_vld   <= '0;
            r_fwd_vld    <= 1'b0;
        end else if (s1_fire) begin
            case (gate)
                GATE_VECTOR: r_vector_cnt <= n_cnt;
                GATE_CUBE:   r_cube_cnt   <= n_cnt;
                GATE_STREAM: begin
                    r_strm_vld[r_s1_sidx] <= 1'b1;
                    r_fwd_vld             <= 1'b1;
                end
                default:     r_global_cnt <= n_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (strm_we) begin
            r_fwd_addr <= r_s1_sidx;
            r_fwd_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op   <= i_opcode;
            r_s1_sidx <= in_sidx;
            r_s1_pool <= i_pool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_granted   <= n_granted;
            r_out_cnt       <= n_cnt;
            r_out_underflow <= n_underflow;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_granted     = r_out_granted;
    assign o_count_after = r_out_cnt;
    assign o_underflow   = r_out_underflow;

`ifndef NO_ASSERTIONS
    a_grant_xor_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_underflow))
        else $error("grant and underflow on one result");

    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_count_after != '0))
        else $error("granted acquire left a zero count");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_underflow) |-> (o_count_after == '0))
        else $error("underflow with a nonzero count");

    a_accept_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_vld)
        else $error("accepted transaction lost before execute");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_sidx) && $stable(r_s1_op)))
        else $error("execute register changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the scoped in-flight limiter
// ----------------------------------------------------------------------------
// a credit model follows every accepted request and queues the result it
// expects; each result taken from the block is compared field by field with
// the oldest queued one. a short directed run covers limit, underflow, scope
// and pool corner cases, then random phases with fresh register settings
// follow, with random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sifl_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 56;

    class credit_scoreboard;
        typedef struct packed {
            logic             granted;
            logic [CNT_W-1:0] count_after;
            logic             underflow;
        } t_credit_result;

        logic [SCOPE_W-1:0] scope;
        logic [CNT_W-1:0]   limit;
        // global, vector and cube gates first, then one gate per stream
        logic [CNT_W-1:0]   gate_count [3+STREAMS];
        t_credit_result     expected_q [$];
        int                 errors;

        function new();
            scope  = SCOPE_GLOBAL;
            limit  = DEPTH_LIMIT_RST;
            errors = 0;
            foreach (gate_count[i]) gate_count[i] = '0;
        endfunction

        function void set_register(logic [CFG_AW-1:0] idx, logic [CNT_W-1:0] data);
            if (idx == CFG_GATE_SCOPE) begin
                scope = data[SCOPE_W-1:0];
            end else if (idx == CFG_DEPTH_LIMIT) begin
                limit = data;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic op, logic [SID_W-1:0] sid,
                                   logic [POOL_W-1:0] pool_code);
            t_gate          g;
            int             slot;
            t_credit_result r;
            g = GATE_GLOBAL;
            // unused scope code and pool code both land on the global gate
            if (scope == SCOPE_STREAM) begin
                g = GATE_STREAM;
            end else if (scope == SCOPE_POOL && pool_code == POOL_VECTOR) begin
                g = GATE_VECTOR;
            end else if (scope == SCOPE_POOL && pool_code == POOL_CUBE) begin
                g = GATE_CUBE;
            end
            slot = (g == GATE_STREAM) ? 3 + int'(sid) % STREAMS : int'(g);
            r = '0;
            if (op == OP_ACQUIRE) begin
                if (gate_count[slot] < limit) begin
                    gate_count[slot] = gate_count[slot] + 1'b1;
                    r.granted = 1'b1;
                end
            end else if (gate_count[slot] == '0) begin
                r.underflow = 1'b1;
            end else begin
                gate_count[slot] = gate_count[slot] - 1'b1;
            end
            r.count_after = gate_count[slot];
            expected_q = {expected_q, r};
        endfunction

        function void check_result(logic granted, logic [CNT_W-1:0] count_after,
                                   logic underflow);
            t_credit_result r;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: granted %0d count %0d uf %0d",
                       granted, count_after, underflow);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (granted !== r.granted) begin
                $error("granted: expected %0d, actual %0d", r.granted, granted);
                errors++;
            end
            if (count_after !== r.count_after) begin
                $error("count_after: expected %0d, actual %0d", r.count_after, count_after);
                errors++;
            end
            if (underflow !== r.underflow) begin
                $error("underflow: expected %0d, actual %0d", r.underflow, underflow);
                errors++;
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFG_AW-1:0]   cfg_idx       = '0;
    logic [CNT_W-1:0]    cfg_wdata     = '0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic                req_opcode    = OP_ACQUIRE;
    logic [SID_W-1:0]    req_stream_id = '0;
    logic [POOL_W-1:0]   req_pool      = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic                granted;
    logic [CNT_W-1:0]    count_after;
    logic                underflow;

    bit                  tx_idle       = 1'b0;
    bit                  rx_idle       = 1'b0;
    bit                  hold_off_req  = 1'b0;
    int                  stall_cycles  = 0;
    credit_scoreboard    sb;

    scoped_in_flight_limiter_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (req_opcode),
        .i_stream_id   (req_stream_id),
        .i_pool        (req_pool),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_granted     (granted),
        .o_count_after (count_after),
        .o_underflow   (underflow)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic op, input logic [SID_W-1:0] sid,
                                input logic [POOL_W-1:0] pool_code);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_opcode    <= op;
        req_stream_id <= sid;
        req_pool      <= pool_code;
        do @(posedge clk); while (!in_ready);
        sb.note_request(op, sid, pool_code);
    endtask

    // wait for every expected result, then settle to catch stray ones
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_AW-1:0] idx,
                                  input logic [CNT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic reconfigure(input logic [CNT_W-1:0] scope_data,
                               input logic [CNT_W-1:0] lim);
        drain();
        write_register(CFG_GATE_SCOPE, scope_data);
        write_register(CFG_DEPTH_LIMIT, lim);
        cfg_we <= 1'b0;
    endtask

    initial begin : result_sink
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(granted, count_after, underflow);
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CNT_W-1:0] lim;
        logic [SID_W-1:0] hot_stream;
        logic [SID_W-1:0] sid;
        logic             op;
        int               acquire_pct;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // reset setting: global gate with limit 8, so the ninth acquire is refused
        for (int i = 0; i < 9; i++) begin
            send_request(OP_ACQUIRE, (i == 0) ? SID_W'(63) : SID_W'(i), POOL_W'(i % 4));
        end

        // unused scope code with upper data bits set, limit now below the count
        reconfigure(10'h3FF, 10'd3);
        send_request(OP_ACQUIRE, SID_W'(5), POOL_VECTOR);
        send_request(OP_ACQUIRE, SID_W'(6), POOL_CUBE);
        for (int i = 0; i < 6; i++) begin
            send_request(OP_RELEASE, SID_W'(i * 11), POOL_W'(i % 4));
        end
        send_request(OP_ACQUIRE, SID_W'(0), POOL_W'(3));
        send_request(OP_ACQUIRE, SID_W'(1), POOL_W'(2));

        // pool gates with a zero limit; pool 3 falls back to the global gate
        reconfigure(CNT_W'(SCOPE_POOL), 10'd0);
        send_request(OP_ACQUIRE, SID_W'(2), POOL_VECTOR);
        send_request(OP_RELEASE, SID_W'(3), POOL_CUBE);
        send_request(OP_RELEASE, SID_W'(4), POOL_W'(3));
        send_request(OP_ACQUIRE, SID_W'(5), POOL_W'(3));

        // per-stream gates at the largest limit, release at zero on stream 63
        reconfigure(CNT_W'(SCOPE_STREAM), 10'h3FF);
        send_request(OP_ACQUIRE, SID_W'(0), POOL_VECTOR);
        send_request(OP_ACQUIRE, SID_W'(63), POOL_CUBE);
        send_request(OP_RELEASE, SID_W'(63), POOL_W'(2));
        send_request(OP_RELEASE, SID_W'(63), POOL_W'(3));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = '1;
                2, 3:    lim = CNT_W'($urandom_range(1, 4));
                4:       lim = CNT_W'($urandom_range(5, 16));
                default: lim = CNT_W'($urandom_range(0, 1023));
            endcase
            reconfigure(CNT_W'($urandom_range(0, 1023)), lim);
            tx_idle     = ($urandom_range(0, 2) != 0);
            rx_idle     = ($urandom_range(0, 2) != 0);
            acquire_pct = $urandom_range(25, 75);
            hot_stream  = SID_W'($urandom_range(0, 63));
            // long result stall with a sender that never pauses
            if (phase == 1) begin
                tx_idle      = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op  = ($urandom_range(0, 99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE;
                // half the traffic hammers a few streams so their gates fill up
                sid = ($urandom_range(0, 1) != 0) ?
                      hot_stream + SID_W'($urandom_range(0, 2)) :
                      SID_W'($urandom_range(0, 63));
                send_request(op, sid, POOL_W'($urandom_range(0, 3)));
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/sifl_pkg.sv
sv/sifl_ram.sv
sv/scoped_in_flight_limiter_unit.sv
bench/tb_top.sv
